// ===== hw/rtl/digest_auth_param_tokenizer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the digest parameter tokenizer.
// Each macro expands to one labeled concurrent assertion that is clocked
// on the rising edge and is switched off while reset is held.
// ----------------------------------------------------------------------------
`ifndef DIGEST_AUTH_PARAM_TOKENIZER_TOP_ASSERT_SVH
`define DIGEST_AUTH_PARAM_TOKENIZER_TOP_ASSERT_SVH

// The consequent is checked in the same cycle as the antecedent.
`define DAPT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error("dapt assertion failed");

// The consequent is checked after the antecedent, by a non-overlapped implication and a further delay.
`define DAPT_ASSERT_LATER(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> ##1 (cons)) else $error("dapt assertion failed");

`endif

// ===== hw/rtl/dapt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dapt_pkg
// Shared types and codes of the digest parameter tokenizer.
// ----------------------------------------------------------------------------
package dapt_pkg;

    // Depth of the request queue between the front and the back.
    localparam int DAPT_QUEUE_DEPTH = 4;

    // Role codes of a result.
    localparam logic [1:0] ROLE_SKIP  = 2'd0;
    localparam logic [1:0] ROLE_NAME  = 2'd1;
    localparam logic [1:0] ROLE_VALUE = 2'd2;

    // Status codes of a result.
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_ERR     = 3'd1;
    localparam logic [2:0] STAT_IGNORED = 3'd2;
    localparam logic [2:0] STAT_HDR_OK  = 3'd3;
    localparam logic [2:0] STAT_HDR_BAD = 3'd4;

    // Character classes found by the front.
    typedef struct packed {
        logic alnum;
        logic space;
        logic underscore;
        logic dash;
        logic equals;
        logic comma;
        logic bslash;
        logic quote;
    } t_class;

    // One classified request as it sits in the queue.
    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        t_class     cls;
    } t_item;

endpackage
`default_nettype wire

// ===== hw/rtl/dapt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dapt_front
// Accepts requests and tags each byte with its C-locale character classes.
// ----------------------------------------------------------------------------
module dapt_front
    import dapt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output      logic       o_in_ready,
    input  wire logic       i_command,
    input  wire logic [7:0] i_data_byte,
    output      logic       o_push_valid,
    input  wire logic       i_push_ready,
    output      t_item      o_push_item
);

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DASH       = 8'h2D;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_BSLASH     = 8'h5C;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    t_class w_cls;
    logic   r_seen_reset;

    // Track that reset has been released so no request enters during it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_reset <= 1'b0;
        end else begin
            r_seen_reset <= 1'b1;
        end
    end

    // Classify the byte; codes 128 and above fall in no class.
    always_comb begin
        w_cls.alnum = (i_data_byte inside {[8'h30:8'h39], [8'h41:8'h5A],
                                           [8'h61:8'h7A]});
        w_cls.space = (i_data_byte == CH_SPACE) ||
                      (i_data_byte inside {[8'h09:8'h0D]});
        w_cls.underscore = (i_data_byte == CH_UNDERSCORE);
        w_cls.dash       = (i_data_byte == CH_DASH);
        w_cls.equals     = (i_data_byte == CH_EQUALS);
        w_cls.comma      = (i_data_byte == CH_COMMA);
        w_cls.bslash     = (i_data_byte == CH_BSLASH);
        w_cls.quote      = (i_data_byte == CH_QUOTE);
    end

    // Hand the classified request straight to the queue.
    assign o_in_ready            = i_push_ready && r_seen_reset;
    assign o_push_valid          = i_in_valid && r_seen_reset;
    assign o_push_item.command   = i_command;
    assign o_push_item.data_byte = i_data_byte;
    assign o_push_item.cls       = w_cls;

endmodule
`default_nettype wire

// ===== hw/rtl/dapt_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dapt_queue
// Small first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
module dapt_queue
    import dapt_pkg::*;
#(
    parameter int DEPTH = DAPT_QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_wr_valid,
    output      logic  o_wr_ready,
    input  wire t_item i_wr_item,
    output      logic  o_rd_valid,
    input  wire logic  i_rd_ready,
    output      t_item o_rd_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_item           r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            w_wr, w_rd;

    assign o_wr_ready = (r_count != FULL_CNT);
    assign o_rd_valid = (r_count != '0);
    assign o_rd_item  = r_mem[r_rd_ptr];
    assign w_wr       = i_wr_valid && o_wr_ready;
    assign w_rd       = o_rd_valid && i_rd_ready;

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + CW'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dapt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dapt_back
// Parse state machine; one request per cycle, while results are taken, into a result register.
// ----------------------------------------------------------------------------
module dapt_back
    import dapt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_pop_valid,
    output      logic       o_pop_ready,
    input  wire t_item      i_pop_item,
    output      logic       o_out_valid,
    input  wire logic       i_out_ready,
    output      logic [7:0] o_echo_byte,
    output      logic [1:0] o_role,
    output      logic       o_pair_done,
    output      logic [2:0] o_status
);

    localparam logic [2:0] ST_SPACE  = 3'd0;
    localparam logic [2:0] ST_NAME   = 3'd1;
    localparam logic [2:0] ST_EQUALS = 3'd2;
    localparam logic [2:0] ST_VALUE  = 3'd3;
    localparam logic [2:0] ST_QUOTED = 3'd4;
    localparam logic [2:0] ST_ESCAPE = 3'd5;
    localparam logic [2:0] ST_AFTER  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_err, n_err;
    logic       r_out_valid;
    logic [7:0] r_echo, n_echo;
    logic [1:0] r_role, n_role;
    logic       r_done, n_done;
    logic [2:0] r_status, n_status;
    logic [2:0] w_next;
    logic       w_bad, w_ok, w_pop;
    t_class     w_c;

    assign w_c         = i_pop_item.cls;
    assign o_pop_ready = !r_out_valid || i_out_ready;
    assign w_pop       = i_pop_valid && o_pop_ready;

    // Next state and result for the request at the queue head.
    always_comb begin
        n_state  = r_state;
        n_err    = r_err;
        n_echo   = i_pop_item.data_byte;
        n_role   = ROLE_SKIP;
        n_done   = 1'b0;
        n_status = STAT_OK;
        w_next   = r_state;
        w_bad    = 1'b0;
        w_ok     = !r_err && ((r_state == ST_VALUE) || (r_state == ST_AFTER));
        if (i_pop_item.command) begin
            // End of header: report, commit a trailing bare value, restart.
            n_echo   = '0;
            n_status = w_ok ? STAT_HDR_OK : STAT_HDR_BAD;
            n_done   = w_ok && (r_state == ST_VALUE);
            n_state  = ST_SPACE;
            n_err    = 1'b0;
        end else if (r_err) begin
            n_status = STAT_IGNORED;
        end else begin
            case (r_state)
                ST_NAME: begin
                    if (w_c.equals) begin
                        w_next = ST_EQUALS;
                    end else if (w_c.alnum || w_c.underscore || w_c.dash) begin
                        n_role = ROLE_NAME;
                    end else begin
                        w_bad = 1'b1;
                    end
                end
                ST_EQUALS: begin
                    if (w_c.alnum || w_c.underscore) begin
                        n_role = ROLE_VALUE;
                        w_next = ST_VALUE;
                    end else if (w_c.quote) begin
                        w_next = ST_QUOTED;
                    end else begin
                        w_bad = 1'b1;
                    end
                end
                ST_QUOTED: begin
                    if (w_c.bslash) begin
                        w_next = ST_ESCAPE;
                    end else if (w_c.quote) begin
                        n_done = 1'b1;
                        w_next = ST_AFTER;
                    end else begin
                        n_role = ROLE_VALUE;
                    end
                end
                ST_ESCAPE: begin
                    n_role = ROLE_VALUE;
                    w_next = ST_QUOTED;
                end
                ST_VALUE: begin
                    if (w_c.space) begin
                        n_done = 1'b1;
                        w_next = ST_AFTER;
                    end else if (w_c.comma) begin
                        n_done = 1'b1;
                        w_next = ST_SPACE;
                    end else begin
                        n_role = ROLE_VALUE;
                    end
                end
                ST_AFTER: begin
                    if (w_c.comma) begin
                        w_next = ST_SPACE;
                    end else if (!w_c.space) begin
                        w_bad = 1'b1;
                    end
                end
                default: begin
                    // Space skipping, and the unused code behaves the same.
                    if (w_c.alnum || w_c.underscore || w_c.dash) begin
                        n_role = ROLE_NAME;
                        w_next = ST_NAME;
                    end else if (w_c.space) begin
                        w_next = ST_SPACE;
                    end else begin
                        w_bad = 1'b1;
                    end
                end
            endcase
            // The first syntax error freezes the state and becomes sticky.
            if (w_bad) begin
                n_err    = 1'b1;
                n_role   = ROLE_SKIP;
                n_done   = 1'b0;
                n_status = STAT_ERR;
            end else begin
                n_state = w_next;
            end
        end
    end

    // Control state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SPACE;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_state     <= n_state;
                r_err       <= n_err;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_echo   <= n_echo;
            r_role   <= n_role;
            r_done   <= n_done;
            r_status <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_echo_byte = r_echo;
    assign o_role      = r_role;
    assign o_pair_done = r_done;
    assign o_status    = r_status;

endmodule
`default_nettype wire

// ===== hw/rtl/digest_auth_param_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// digest_auth_param_tokenizer_top: tags Digest header bytes as name or value.
// A request is written into the queue and popped from it into the parser's result register.
// Throughput: one request per cycle while results are taken (single-step parser).
// Reset (synchronous, active low) empties the queue and restarts the parser.
// ----------------------------------------------------------------------------
`default_nettype none
`include "digest_auth_param_tokenizer_top_assert.svh"
module digest_auth_param_tokenizer_top
    import dapt_pkg::*;
#(
    parameter int QUEUE_DEPTH = DAPT_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output      logic       o_in_ready,
    input  wire logic       i_command,
    input  wire logic [7:0] i_data_byte,
    output      logic       o_out_valid,
    input  wire logic       i_out_ready,
    output      logic [7:0] o_echo_byte,
    output      logic [1:0] o_role,
    output      logic       o_pair_done,
    output      logic [2:0] o_status
);

    logic  w_push_valid, w_push_ready;
    t_item w_push_item;
    logic  w_pop_valid, w_pop_ready;
    t_item w_pop_item;

    // Front: accept and classify.
    dapt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_data_byte  (i_data_byte),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_item  (w_push_item)
    );

    // Queue between the two sides.
    dapt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_push_valid),
        .o_wr_ready (w_push_ready),
        .i_wr_item  (w_push_item),
        .o_rd_valid (w_pop_valid),
        .i_rd_ready (w_pop_ready),
        .o_rd_item  (w_pop_item)
    );

    // Back: parse and hold the result.
    dapt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_item  (w_pop_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_echo_byte (o_echo_byte),
        .o_role      (o_role),
        .o_pair_done (o_pair_done),
        .o_status    (o_status)
    );

    // A pair can only close on an accepted byte or a good end of header.
    `DAPT_ASSERT_SAME(a_done_status, i_clk, i_rst_n, o_out_valid && o_pair_done, (o_status == STAT_OK) || (o_status == STAT_HDR_OK))
    // Errors, ignored bytes and end reports never carry a name or value role.
    `DAPT_ASSERT_SAME(a_skip_role, i_clk, i_rst_n, o_out_valid && (o_status != STAT_OK), o_role == ROLE_SKIP)
    // End-of-header results carry a zero byte.
    `DAPT_ASSERT_SAME(a_end_echo, i_clk, i_rst_n, o_out_valid && ((o_status == STAT_HDR_OK) || (o_status == STAT_HDR_BAD)), o_echo_byte == 8'd0)
    // A request taken while the queue is empty and the result slot is free is expected
    // to pass through the queue into the result register and come out valid, with no stall.
    `DAPT_ASSERT_LATER(a_latency, i_clk, i_rst_n, i_in_valid && o_in_ready && !w_pop_valid && (!o_out_valid || i_out_ready), o_out_valid)

endmodule
`default_nettype wire
